// File: src/lsce_pkg.sv
// Shared constants and types for the line sensor centroid error block.
package lsce_pkg;

    localparam int MAX_SENSORS   = 8;
    localparam int FRAC_BITS     = 8;

    localparam int IN_W          = 8;
    localparam int CFG_W         = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int ERR_W         = 12;
    localparam int MISS_W        = 16;
    localparam int TDATA_W       = ((ERR_W + MISS_W + 7) / 8) * 8;

    localparam int LANE_W        = $clog2(MAX_SENSORS);
    localparam int CNT_W         = $clog2(MAX_SENSORS + 1);
    localparam int WGT_W         = LANE_W + 2;
    localparam int SUM_W         = $clog2(MAX_SENSORS * MAX_SENSORS) + 1;
    localparam int MAG_W         = SUM_W - 1;
    localparam int DVD_W         = MAG_W + FRAC_BITS;
    localparam int STEP_BITS     = 4;
    localparam int DIV_STEPS     = (DVD_W + STEP_BITS - 1) / STEP_BITS;
    localparam int DVD_PAD       = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W    = $clog2(DIV_STEPS + 1);

    localparam int DEFAULT_COUNT = 5;
    localparam int ERR_POS_LIM   = (1 << (ERR_W - 1)) - 1;
    localparam int ERR_NEG_LIM   = 1 << (ERR_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_SENSORS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY = CFG_IDX_W'(1);

    // merged lane results: signed weight sum and number of active sensors
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } merge_t;

endpackage

// File: src/line_sensor_centroid_error.sv
// Top level: line position error from a row of digital line sensors.
//
//  channel  | signals                               | content
//  ---------+---------------------------------------+-------------------------------
//  input    | s_tvalid s_tready s_tdata[7:0]        | sensor_bits
//  output   | m_tvalid m_tready m_tdata m_tuser     | line_error, lost_samples, line_lost
//  config   | cfg_valid cfg_ready cfg_index cfg_data| 0 sensors_in_use, 1 active_polarity
//
// Flow: an item with an active sensor goes from accept through EVAL and the
// 4-bit-per-cycle divider (DIV) to OUT, where the output register is loaded;
// an item with no active sensor goes from EVAL straight to OUT.
// One item is in work at a time; the next is taken while a result waits.
// Reset clears the config to 5 sensors, active-high, error and lost count to 0.
// A stalled output holds the block in its output state until the result moves.
module line_sensor_centroid_error
    import lsce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input item
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,     // [7:0] sensor_bits
    // result item
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,     // [11:0] line_error, [27:12] lost_samples
    output logic                  m_tuser,     // [0] line_lost
    // config writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [CFG_W-1:0]         sensors_reg;
    logic                     polarity_reg;
    merge_t                   merge_reg;
    logic                     sign_reg;
    logic [ERR_W-1:0]         held_error_reg;
    logic [MISS_W-1:0]        miss_reg;
    logic                     m_tvalid_reg;
    logic [ERR_W-1:0]         out_error_reg;
    logic [MISS_W-1:0]        out_miss_reg;

    logic [CNT_W-1:0]         n_eff;
    logic [MAX_SENSORS-1:0]   lane_active;
    logic [WGT_W-1:0]         lane_weight [MAX_SENSORS];
    merge_t                   merged;
    logic                     in_accept;
    logic                     out_load;
    logic                     sum_neg;
    logic [SUM_W-1:0]         sum_abs;
    logic                     div_start;
    logic                     div_done;
    logic [DVD_PAD-1:0]       div_q;
    logic [DVD_PAD-1:0]       div_q_neg;
    logic [ERR_W-1:0]         err_sat;

    // zero means the default five-sensor row; clip to the lane count
    always_comb
    begin
        if (sensors_reg == '0)
            n_eff = CNT_W'(DEFAULT_COUNT);
        else if (32'(sensors_reg) > MAX_SENSORS)
            n_eff = CNT_W'(MAX_SENSORS);
        else
            n_eff = CNT_W'(sensors_reg);
    end

    // one lane per sensor; lanes past the input width read zero
    for (genvar i = 0; i < MAX_SENSORS; i++)
    begin : g_lane
        logic lane_bit;
        if (i < IN_W)
        begin : g_bit
            assign lane_bit = s_tdata[i];
        end
        else
        begin : g_zero
            assign lane_bit = 1'b0;
        end

        lsce_lane u_lane (
            .sensor_bit (lane_bit),
            .polarity   (polarity_reg),
            .n_eff      (n_eff),
            .lane_idx   (LANE_W'(i)),
            .active     (lane_active[i]),
            .weight     (lane_weight[i])
        );
    end

    lsce_merge u_merge (
        .active (lane_active),
        .weight (lane_weight),
        .merged (merged)
    );

    assign sum_neg   = merge_reg.sum < 0;
    assign sum_abs   = sum_neg ? SUM_W'(-merge_reg.sum) : SUM_W'(merge_reg.sum);
    assign div_start = (state_reg == ST_EVAL) && (merge_reg.count != '0);

    lsce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (sum_abs[MAG_W-1:0]),
        .divisor  (merge_reg.count),
        .done     (div_done),
        .quotient (div_q)
    );

    // apply the sign and saturate to the error width
    assign div_q_neg = -div_q;
    always_comb
    begin
        if (sign_reg)
        begin
            if (div_q > DVD_PAD'(ERR_NEG_LIM))
                err_sat = ERR_W'(ERR_NEG_LIM);
            else
                err_sat = div_q_neg[ERR_W-1:0];
        end
        else
        begin
            if (div_q > DVD_PAD'(ERR_POS_LIM))
                err_sat = ERR_W'(ERR_POS_LIM);
            else
                err_sat = div_q[ERR_W-1:0];
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (merge_reg.count == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sensors_reg    <= CFG_W'(DEFAULT_COUNT);
            polarity_reg   <= 1'b1;
            held_error_reg <= '0;
            miss_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SENSORS)
                    sensors_reg <= cfg_data;
                else if (cfg_index == REG_POLARITY)
                    polarity_reg <= cfg_data[0];
            end

            // lost sample: hold the error, count up to saturation
            if ((state_reg == ST_EVAL) && (merge_reg.count == '0))
            begin
                if (miss_reg != {MISS_W{1'b1}})
                    miss_reg <= miss_reg + MISS_W'(1);
            end

            if ((state_reg == ST_DIV) && div_done)
            begin
                held_error_reg <= err_sat;
                miss_reg       <= '0;
            end

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            merge_reg <= merged;
        if (state_reg == ST_EVAL)
            sign_reg <= sum_neg;
        if (out_load)
        begin
            out_error_reg <= held_error_reg;
            out_miss_reg  <= miss_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({out_miss_reg, out_error_reg});
    assign m_tuser  = (out_miss_reg != '0);

endmodule

// File: src/lsce_lane.sv
// One sensor lane: active test and signed position weight.
module lsce_lane
    import lsce_pkg::*;
(
    input  logic                    sensor_bit,
    input  logic                    polarity,
    input  logic [CNT_W-1:0]        n_eff,
    input  logic [LANE_W-1:0]       lane_idx,
    output logic                    active,
    output logic signed [WGT_W-1:0] weight
);

    logic [WGT_W-1:0] twice_idx;
    logic [WGT_W-1:0] n_ext;
    logic             in_use;

    assign twice_idx = WGT_W'({lane_idx, 1'b0});
    assign n_ext     = WGT_W'(n_eff);
    assign in_use    = CNT_W'(lane_idx) < n_eff;
    assign active    = in_use && (sensor_bit == polarity);

    // weight = 2i - (n - 1), zero when the lane does not count
    assign weight = active ? $signed(twice_idx - n_ext + WGT_W'(1)) : '0;

endmodule

// File: src/lsce_merge.sv
// Merges lane outputs into a weight sum and an active count.
module lsce_merge
    import lsce_pkg::*;
(
    input  logic [MAX_SENSORS-1:0]  active,
    input  logic [WGT_W-1:0]        weight [MAX_SENSORS],
    output merge_t                  merged
);

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
        sum = '0;
        cnt = '0;
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            sum = sum + SUM_W'($signed(weight[i]));
            cnt = cnt + CNT_W'(active[i]);
        end
        merged.sum   = sum;
        merged.count = cnt;
    end

endmodule

// File: src/lsce_div.sv
// Unsigned divider, STEP_BITS quotient bits per cycle, restoring.
module lsce_div
    import lsce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MAG_W-1:0]    mag,
    input  logic [CNT_W-1:0]    divisor,
    output logic                done,
    output logic [DVD_PAD-1:0]  quotient
);

    logic [DVD_PAD-1:0]    dvd_reg, dvd_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      div_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_comb
    begin
        logic [CNT_W:0] trial;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            trial    = {rem_next, dvd_next[DVD_PAD-1]};
            dvd_next = {dvd_next[DVD_PAD-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial       = trial - {1'b0, div_reg};
                dvd_next[0] = 1'b1;
            end
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_CNT_W'(1);
                if (step_reg == STEP_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DVD_PAD'({mag, {FRAC_BITS{1'b0}}});
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: src/lsce_checker.sv
// Port-level checks for the line sensor centroid error block, with bind.
module lsce_checker
    import lsce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,
    input  logic                  m_tuser
);

    // stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // lost flag agrees with the lost count
    a_lost_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (m_tdata[ERR_W+MISS_W-1:ERR_W] != '0)))
        else $error("line_lost does not match lost_samples");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // a lost result carries no new error: the held error equals the last one
    a_held_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready ##1 m_tvalid && m_tuser
            && (m_tdata[ERR_W+MISS_W-1:ERR_W] != MISS_W'(1))
        |-> m_tdata[ERR_W-1:0] == $past(m_tdata[ERR_W-1:0], 1))
        else $error("held error changed while the line was lost");

endmodule

bind line_sensor_centroid_error lsce_checker u_lsce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/lsce_checker.sv
// Scoreboard for the line sensor block: predicts every reading and compares it with the output.
`timescale 1ns / 1ps

module lsce_scoreboard
    import lsce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [TDATA_W-1:0]   m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int unsigned          mismatches,
    output int unsigned          outstanding
);

    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic signed [ERR_W-1:0] line_error;
        logic                    line_lost;
        logic [MISS_W-1:0]       lost_samples;
    } reading_t;

    logic [CFG_W-1:0]        sensors_cfg;
    logic                    sense_level;
    logic signed [ERR_W-1:0] held_error;
    logic [MISS_W-1:0]       lost_run;
    reading_t                expected_readings[$];
    int unsigned             fail_total = 0;

    // mean weight of the active sensors; updates the held error and lost run
    function automatic reading_t predict_reading(input logic [IN_W-1:0] bits);
        int       lanes;
        int       weight_sum;
        int       hits;
        int       mean;
        logic     lane_bit;
        reading_t r;
        lanes = int'(sensors_cfg);
        if (lanes == 0)
            lanes = DEFAULT_COUNT;
        if (lanes > MAX_SENSORS)
            lanes = MAX_SENSORS;
        weight_sum = 0;
        hits = 0;
        for (int i = 0; i < lanes; i++)
        begin
            lane_bit = (i < IN_W) ? bits[i] : 1'b0;
            if (lane_bit == sense_level)
            begin
                weight_sum += 2 * i - (lanes - 1);
                hits++;
            end
        end
        if (hits == 0)
        begin
            if (lost_run != '1)
                lost_run++;
        end
        else
        begin
            mean = (weight_sum * (1 << FRAC_BITS)) / hits;   // truncates toward zero
            if (mean > ERR_POS_LIM)
                mean = ERR_POS_LIM;
            if (mean < -ERR_NEG_LIM)
                mean = -ERR_NEG_LIM;
            held_error = ERR_W'(mean);
            lost_run = '0;
        end
        r.line_error   = held_error;
        r.line_lost    = (lost_run != '0);
        r.lost_samples = lost_run;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        fail_total++;
        if (fail_total <= PRINT_CAP)
            $display("%0t lsce_checker: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t got;
        reading_t want;
        if (!rst_n)
        begin
            sensors_cfg  = CFG_W'(DEFAULT_COUNT);
            sense_level  = 1'b1;
            held_error   = '0;
            lost_run     = '0;
            expected_readings.delete();
            outstanding <= 0;
            mismatches  <= fail_total;
        end
        else
        begin
            // a result never leaves in the cycle its item is taken, so pop before push
            if (m_tvalid && m_tready)
            begin
                got.line_error   = m_tdata[ERR_W-1:0];
                got.lost_samples = m_tdata[ERR_W +: MISS_W];
                got.line_lost    = m_tuser;
                if (expected_readings.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= PRINT_CAP)
                        $display("%0t lsce_checker: unexpected item, actual error %0d lost %0d",
                                 $time, got.line_error, got.lost_samples);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.line_error !== want.line_error)
                        note_mismatch("line_error", want.line_error, got.line_error);
                    if (got.line_lost !== want.line_lost)
                        note_mismatch("line_lost", want.line_lost, got.line_lost);
                    if (got.lost_samples !== want.lost_samples)
                        note_mismatch("lost_samples", want.lost_samples, got.lost_samples);
                end
            end
            if (s_tvalid && s_tready)
                expected_readings.push_back(predict_reading(s_tdata));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SENSORS)
                    sensors_cfg = cfg_data;
                else if (cfg_index == REG_POLARITY)
                    sense_level = cfg_data[0];
            end
            outstanding <= expected_readings.size();
            mismatches  <= fail_total;
        end
    end

endmodule

// File: tb/sv/tb.sv
// Top of the line sensor testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb
    import lsce_pkg::*;
();

    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 150;
    // cycles without any input, output or config handshake before the run is declared hung
    localparam int STALL_LIMIT     = 3000;
    // settle time after the last result has come back
    localparam int DRAIN_CYCLES    = 12;
    // long lost run before the recovery sample
    localparam int LOST_RUN        = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 200;

    // indexes past the register file; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    // directed samples, five sensors active high (reset setting)
    localparam logic [IN_W-1:0] DIR_FIVE[10] = '{
        8'h00, 8'h00,   // lost twice from reset: error held at zero
        8'h01, 8'h10,   // outermost sensors, -4 and +4
        8'h04, 8'h1F,   // center alone, all five
        8'h0B, 8'h1A,   // thirds: truncation toward zero on both signs
        8'hE0,          // only bits past sensor 4: counts as lost
        8'h06
    };
    // eight sensors active high: full scale on both ends
    localparam logic [IN_W-1:0] DIR_EIGHT[5] = '{8'h01, 8'h80, 8'h0B, 8'hFF, 8'h00};
    // eight sensors active low
    localparam logic [IN_W-1:0] DIR_LOW[4]   = '{8'hFF, 8'hFE, 8'h7F, 8'h00};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned quiet_cycles = 0;

    bit   calm    = 1'b0;   // no idling on either side
    bit   rx_hold = 1'b0;   // request one long receiver hold-off
    int   lanes_now = DEFAULT_COUNT;   // stimulus-side copy of the setting
    logic level_now = 1'b1;

    always #2 clk = ~clk;

    line_sensor_centroid_error dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lsce_scoreboard line_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // single reset at the start of the run
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: random stalls, none while calm, plus one long hold-off on request.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            m_tready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // Watchdog: a correct run always moves something within the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One sensor sample. Mostly a line under one to three neighboring sensors,
    // then lost samples, all sensors on the line, and plain noise. Bits past
    // the sensors in use are always random.
    function automatic logic [IN_W-1:0] line_sample(input bit lost_only);
        logic [IN_W-1:0] lane_mask;
        logic [IN_W-1:0] on_line;
        int              pick;
        int              width;
        int              left;
        lane_mask = IN_W'((1 << lanes_now) - 1);
        pick = lost_only ? 60 : $urandom_range(99);
        if (pick < 55)
        begin
            width   = $urandom_range(1, 3);
            left    = $urandom_range(0, lanes_now - 1);
            on_line = IN_W'(((1 << width) - 1) << left);
        end
        else if (pick < 70)
            on_line = '0;
        else if (pick < 78)
            on_line = lane_mask;
        else
            on_line = IN_W'($urandom);
        on_line = (on_line & lane_mask) | (IN_W'($urandom) & ~lane_mask);
        return level_now ? on_line : ~on_line;
    endfunction

    // offer one item; returns at the edge where it was taken
    task automatic offer_sample(input logic [IN_W-1:0] bits);
        while (!calm && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // sender pauses until every expected result is back and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no extra edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_SENSORS)
            lanes_now = (val == 0) ? DEFAULT_COUNT
                      : (int'(val) > MAX_SENSORS) ? MAX_SENSORS : int'(val);
        else if (idx == REG_POLARITY)
            level_now = val[0];
    endtask

    // new setting, written only with the block idle; spare writes hit unused indexes
    task automatic reconfigure(input logic [CFG_W-1:0] count_val, input logic level_val,
                               input bit spare);
        drain();
        write_reg(REG_SENSORS, count_val);
        write_reg(REG_POLARITY, CFG_W'(level_val));
        if (spare)
        begin
            write_reg(REG_SPARE_LO, CFG_W'($urandom));
            write_reg(REG_SPARE_HI, CFG_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int              sent;
        int              burst;
        logic [CFG_W-1:0] count_val;
        logic            level_val;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // ---- directed part ----
        foreach (DIR_FIVE[i])
            offer_sample(DIR_FIVE[i]);
        reconfigure(CFG_W'(8), 1'b1, 1'b0);
        foreach (DIR_EIGHT[i])
            offer_sample(DIR_EIGHT[i]);
        reconfigure(CFG_W'(8), 1'b0, 1'b0);
        foreach (DIR_LOW[i])
            offer_sample(DIR_LOW[i]);
        // one sensor, active low; spare indexes written with random data
        reconfigure(CFG_W'(1), 1'b0, 1'b1);
        offer_sample(8'h00);
        offer_sample(8'h01);
        offer_sample(8'hFE);
        // zero count falls back to five sensors
        reconfigure(CFG_W'(0), 1'b1, 1'b0);
        offer_sample(8'h10);
        offer_sample(8'h20);
        // count above the sensor row is limited to eight
        reconfigure(CFG_W'(15), 1'b1, 1'b0);
        offer_sample(8'h80);

        // ---- random phases, each under its own setting ----
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       begin count_val = CFG_W'(8);  level_val = 1'b1;         end
                1:       begin count_val = CFG_W'(1);  level_val = 1'b0;         end
                2:       begin count_val = CFG_W'(0);  level_val = 1'($urandom_range(1)); end
                3:       begin count_val = CFG_W'(15); level_val = 1'b1;         end
                4:       begin count_val = CFG_W'(2);  level_val = 1'b0;         end
                default: begin count_val = CFG_W'($urandom); level_val = 1'($urandom_range(1)); end
            endcase
            reconfigure(count_val, level_val, 1'($urandom_range(1)));
            calm = (p == 3);   // one whole phase without idling
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 3)
                begin
                    // a run of lost samples builds up the counter
                    burst = $urandom_range(5, 40);
                    repeat (burst) offer_sample(line_sample(1'b1));
                    sent += burst;
                end
                else
                begin
                    offer_sample(line_sample(1'b0));
                    sent++;
                end
                if ($urandom_range(99) < 2)
                    drain();
            end
            calm = 1'b0;
        end

        // ---- back-pressure: receiver holds off while items keep coming ----
        reconfigure(CFG_W'(6), 1'b1, 1'b0);
        rx_hold = 1'b1;
        repeat (24) offer_sample(line_sample(1'b0));
        drain();

        // ---- long lost run, then recovery ----
        reconfigure(CFG_W'(1), 1'b1, 1'b0);
        calm = 1'b1;
        repeat (LOST_RUN) offer_sample(line_sample(1'b1));
        calm = 1'b0;
        offer_sample(8'h01);
        offer_sample(8'h00);

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
